/* sv/spq_pkg.sv */
// Package for the sorted priority queue: command and status codes,
// and the structs passed between the top level and the cell row.
// No dependencies.
`default_nettype none

package spq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // broadcast to every cell
  typedef struct packed {
    logic                       ins;
    logic signed [VALUE_W-1:0]  value;
  } ctrl_t;

  // handed from a cell to its tail-side neighbour
  typedef struct packed {
    logic                       ge;
    logic signed [VALUE_W-1:0]  entry;
  } link_t;

endpackage

`default_nettype wire

/* sv/spq_cell.sv */
// One slot of the sorted queue: holds an entry and shifts on insert.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
  input  wire logic          clk,
  input  wire spq_pkg::ctrl_t ctrl,
  input  wire logic          occupied,
  input  wire spq_pkg::link_t left,
  output spq_pkg::link_t     right
);

  logic signed [spq_pkg::VALUE_W-1:0] entry;
  logic signed [spq_pkg::VALUE_W-1:0] entry_next;
  logic                               ge;

  assign ge = occupied && (entry >= ctrl.value);

  always_comb begin
    if (ge) begin
      entry_next = entry;
    end else if (left.ge) begin
      entry_next = ctrl.value;
    end else begin
      entry_next = left.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      entry <= entry_next;
    end
  end

  assign right.ge    = ge;
  assign right.entry = entry;

endmodule

`default_nettype wire

/* sv/sorted_priority_queue.sv */
// Sorted priority queue, top level: fill count, result register, cell row.
// Depends on spq_pkg and spq_cell.
`default_nettype none

// Keeps up to CAPACITY signed 32-bit values in descending order in a row of
// cells, each comparing its entry with the incoming value so an insert
// lands in place, all cells updating together. One request is taken per cycle and its
// result appears in the output register on the next; a stalled output only
// holds the input off when the result register is still full. Commands:
// insert, remove smallest, clear; code 3 reports the state unchanged.
// Entries come out of reset undefined; the fill count alone marks them.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // value[31:0]
  input  wire logic [1:0]  s_tuser,   // cmd[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // largest[31:0], empty_res[32], count[37:33], status[39:38]
);

  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam logic [FW-1:0] CAP_F = FW'(CAPACITY);

  logic                               accept;
  spq_pkg::cmd_t                      cmd;
  logic [FW-1:0]                      fill;
  logic [FW-1:0]                      fill_next;
  spq_pkg::status_t                   status_next;
  logic                               ins_ok;
  spq_pkg::ctrl_t                     ctrl;
  spq_pkg::link_t                     links [CAPACITY+1];
  logic signed [spq_pkg::VALUE_W-1:0] head_next;
  logic [FW+spq_pkg::COUNT_W-1:0]     fill_ext;

  logic signed [spq_pkg::VALUE_W-1:0] res_largest;
  logic                               res_empty;
  logic [spq_pkg::COUNT_W-1:0]        res_count;
  spq_pkg::status_t                   res_status;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign cmd      = spq_pkg::cmd_t'(s_tuser);

  always_comb begin
    fill_next   = fill;
    status_next = spq_pkg::ST_OK;
    ins_ok      = 1'b0;
    case (cmd)
      spq_pkg::CMD_INSERT: begin
        if (fill == CAP_F) begin
          status_next = spq_pkg::ST_FULL;
        end else begin
          ins_ok    = 1'b1;
          fill_next = fill + 1'b1;
        end
      end
      spq_pkg::CMD_REMOVE: begin
        if (fill == '0) begin
          status_next = spq_pkg::ST_EMPTY;
        end else begin
          fill_next = fill - 1'b1;
        end
      end
      spq_pkg::CMD_CLEAR: begin
        fill_next = '0;
      end
      default: begin
        fill_next = fill;
      end
    endcase
  end

  assign ctrl.ins   = accept && ins_ok;
  assign ctrl.value = $signed(s_tdata);

  // head side of the row always accepts the new value
  assign links[0].ge    = 1'b1;
  assign links[0].entry = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [FW-1:0] IDX = FW'(i);
    spq_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (IDX < fill),
      .left     (links[i]),
      .right    (links[i+1])
    );
  end

  always_comb begin
    if (fill_next == '0) begin
      head_next = '0;
    end else if (ins_ok && !links[1].ge) begin
      head_next = ctrl.value;
    end else begin
      head_next = links[1].entry;
    end
  end

  assign fill_ext = {{spq_pkg::COUNT_W{1'b0}}, fill_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        fill <= fill_next;
      end
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_largest <= head_next;
      res_empty   <= (fill_next == '0);
      res_count   <= fill_ext[spq_pkg::COUNT_W-1:0];
      res_status  <= status_next;
    end
  end

  assign m_tdata = {res_status, res_count, res_empty, res_largest};

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= CAP_F)
    else $error("fill count beyond capacity");

  a_empty_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res_empty == (fill == '0)))
    else $error("empty flag disagrees with fill count");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == spq_pkg::CMD_CLEAR) |=> (m_tvalid && res_empty && fill == '0))
    else $error("clear did not empty the queue");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (fill >= FW'(2)) |-> (links[1].entry >= links[2].entry))
    else $error("head entries out of order");

endmodule

`default_nettype wire

/* tb/tb_sorted_priority_queue.sv */
// Self-checking bench for sorted_priority_queue: directed and random command
// streams, bursty sender, stalling receiver, in-bench priority queue predictor.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 16;
  localparam int N_ITEMS = 1150;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] CMD_NOP = 2'd3;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] value;
    bit                 drain;
  } request_t;

  typedef struct {
    logic signed [31:0] largest;
    logic               empty_res;
    logic [4:0]         count;
    spq_pkg::status_t   status;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  request_t cmd_backlog[$];
  report_t  due_reports[$];
  request_t in_flight;

  logic signed [31:0] shadow_entries [CAPACITY];
  int shadow_fill = 0;

  int mismatches = 0;
  int reports_seen = 0;
  int cycles = 0;
  int burst_left = 4;
  int gap_left = 0;
  int hold_left = 0;
  int hold_count = 0;
  int phase_left = 0;
  int ready_mode = 0;

  sorted_priority_queue #(.CAPACITY(CAPACITY)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic report_t apply_command(request_t r);
    report_t rep;
    int pos;
    rep.status = spq_pkg::ST_OK;
    case (r.cmd)
      spq_pkg::CMD_INSERT: begin
        if (shadow_fill >= CAPACITY) begin
          rep.status = spq_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_fill && shadow_entries[pos] >= r.value) pos++;
          for (int i = shadow_fill; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[pos] = r.value;
          shadow_fill++;
        end
      end
      spq_pkg::CMD_REMOVE: begin
        if (shadow_fill == 0) rep.status = spq_pkg::ST_EMPTY;
        else shadow_fill--;
      end
      spq_pkg::CMD_CLEAR: shadow_fill = 0;
      default: ;
    endcase
    rep.largest = (shadow_fill > 0) ? shadow_entries[0] : '0;
    rep.empty_res = (shadow_fill == 0);
    rep.count = shadow_fill[4:0];
    return rep;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // sender: bursts with random gaps, optional drain before a request
  always @(posedge clk) begin
    logic nxt_valid;
    request_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
    end else begin
      if (s_tvalid && s_tready) due_reports.push_back(apply_command(in_flight));
      if (!s_tvalid || s_tready) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].drain && due_reports.size() != 0)) begin
          r = cmd_backlog.pop_front();
          in_flight = r;
          s_tdata <= r.value;
          s_tuser <= r.cmd;
          nxt_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        s_tvalid <= nxt_valid;
      end
    end
  end

  // receiver: stall pattern changes every so often, plus two long hold-offs
  always @(posedge clk) begin
    logic nxt_ready;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
      end else if ((hold_count == 0 && reports_seen >= 200) ||
                   (hold_count == 1 && reports_seen >= 700)) begin
        hold_left = 80;
        hold_count++;
      end
      if (phase_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        phase_left = $urandom_range(16, 64);
      end
      phase_left--;
      case (ready_mode)
        0: nxt_ready = 1'b1;
        1: nxt_ready = 1'($urandom_range(0, 1));
        2: nxt_ready = ($urandom_range(0, 3) == 0);
        default: nxt_ready = phase_left[0];
      endcase
      m_tready <= nxt_ready && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    report_t want;
    if (!rst && m_tvalid && m_tready) begin
      reports_seen++;
      if (due_reports.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[31:0], '0);
      end else begin
        want = due_reports.pop_front();
        if (m_tdata[31:0] !== want.largest)
          report_mismatch("largest", m_tdata[31:0], want.largest);
        if (m_tdata[32] !== want.empty_res)
          report_mismatch("empty_res", 32'(m_tdata[32]), 32'(want.empty_res));
        if (m_tdata[37:33] !== want.count)
          report_mismatch("count", 32'(m_tdata[37:33]), 32'(want.count));
        if (m_tdata[39:38] !== want.status)
          report_mismatch("status", 32'(m_tdata[39:38]), 32'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("sorted_priority_queue test failed");
      $finish;
    end
  end

  function automatic void queue_cmd(logic [1:0] cmd, logic [31:0] value, bit drain);
    request_t r;
    r.cmd = cmd;
    r.value = value;
    r.drain = drain;
    cmd_backlog.push_back(r);
  endfunction

  // mix of wide random, tie-prone small values and extremes
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom;
      3, 4: return $signed($urandom_range(0, 6)) - 3;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  initial begin
    int ins_pct;
    int seg_len;
    int roll;
    bit seg_drain;
    logic [1:0] c;

    // empty-queue corner cases
    queue_cmd(spq_pkg::CMD_REMOVE, 32'h1234_5678, 1'b0);
    queue_cmd(spq_pkg::CMD_CLEAR, 32'hffff_ffff, 1'b0);
    queue_cmd(CMD_NOP, 32'h0, 1'b0);
    // extremes and a tie
    queue_cmd(spq_pkg::CMD_INSERT, 32'h7fff_ffff, 1'b0);
    queue_cmd(spq_pkg::CMD_INSERT, 32'h8000_0000, 1'b0);
    queue_cmd(spq_pkg::CMD_INSERT, 32'h0, 1'b0);
    queue_cmd(spq_pkg::CMD_INSERT, 32'hffff_ffff, 1'b0);
    queue_cmd(spq_pkg::CMD_INSERT, 32'h0, 1'b0);
    queue_cmd(spq_pkg::CMD_INSERT, 32'h1, 1'b0);
    queue_cmd(spq_pkg::CMD_REMOVE, 32'h0, 1'b0);
    queue_cmd(CMD_NOP, 32'hffff_ffff, 1'b0);
    // fill to capacity, then insert into a full queue
    for (int i = 0; i < 11; i++)
      queue_cmd(spq_pkg::CMD_INSERT,
                (i % 2) ? 32'haaaa_aaaa + i : 32'h5555_5555 - i, 1'b0);
    queue_cmd(spq_pkg::CMD_INSERT, 32'h7fff_fffe, 1'b0);
    queue_cmd(spq_pkg::CMD_CLEAR, 32'h0, 1'b0);

    // random segments biased towards filling or draining, or balanced between the two
    while (cmd_backlog.size() < N_ITEMS) begin
      case ($urandom_range(0, 2))
        0: ins_pct = 85;
        1: ins_pct = 50;
        default: ins_pct = 20;
      endcase
      seg_len = $urandom_range(20, 60);
      seg_drain = (cmd_backlog.size() < 30) || ($urandom_range(0, 5) == 0);
      for (int k = 0; k < seg_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) c = spq_pkg::CMD_CLEAR;
        else if (roll < 7) c = CMD_NOP;
        else if (roll < 7 + ins_pct * 93 / 100) c = spq_pkg::CMD_INSERT;
        else c = spq_pkg::CMD_REMOVE;
        queue_cmd(c, pick_value(), seg_drain && k == 0);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || s_tvalid) @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("sorted_priority_queue test passed");
    else
      $display("sorted_priority_queue test failed");
    $finish;
  end

endmodule

/* sim.f */
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
tb/tb_sorted_priority_queue.sv
